[hdl/bqc_pkg.sv]
// Shared definitions for the biquad filter: fixed-point constants, control codes,
// the microword layout and the microprogram ROM used by the sequencer.
// No dependencies.
`default_nettype none

package bqc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF   = 40;
    localparam int COEF_FRAC        = 28;
    localparam int STATE_WIDTH      = 64;
    localparam longint COEF_ONE     = 64'sd1 <<< COEF_FRAC;

    localparam int STEP_WIDTH = 5;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [STEP_WIDTH-1:0] step_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B0           = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B1           = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B2           = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_A1           = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_A2           = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SECOND_ORDER = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLAMP_LOW    = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLAMP_HIGH   = 3'd7;

    typedef enum logic [1:0] {
        CMD_FILTER = 2'd0,
        CMD_CLAMP  = 2'd1,
        CMD_STEADY = 2'd2,
        CMD_DIFF   = 2'd3
    } cmd_t;

    typedef enum logic {
        A_X = 1'b0,
        A_Y = 1'b1
    } a_sel_t;

    typedef enum logic [2:0] {
        B_B0    = 3'd0,
        B_B1    = 3'd1,
        B_B2    = 3'd2,
        B_A1    = 3'd3,
        B_A2    = 3'd4,
        B_OMB0  = 3'd5,
        B_A1MB1 = 3'd6
    } b_sel_t;

    typedef enum logic [1:0] {
        BASE_ACC  = 2'd0,
        BASE_ZERO = 2'd1,
        BASE_S0   = 2'd2,
        BASE_S1Z  = 2'd3
    } base_sel_t;

    typedef enum logic [2:0] {
        ADD_NONE  = 3'd0,
        ADD_PLUS  = 3'd1,
        ADD_MINUS = 3'd2,
        ADD_RND   = 3'd3,
        ADD_S0    = 3'd4
    } add_sel_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_DISPATCH = 3'd1,
        J_IF_FIRST = 3'd2,
        J_END      = 3'd3,
        J_EMIT     = 3'd4
    } jump_t;

    typedef struct packed {
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        logic      hi_half;
        base_sel_t base_sel;
        add_sel_t  add_sel;
        logic      take_y;
        logic      wr_s0;
        logic      wr_s1;
        jump_t     jump;
        step_t     target;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   load;
        logic   emit;
    } seq_ctl_t;

    // Microprogram entry points.
    localparam step_t ST_IDLE   = 5'd0;
    localparam step_t ST_FILT   = 5'd1;
    localparam step_t ST_EMIT   = 5'd13;
    localparam step_t ST_STEADY = 5'd14;
    localparam step_t ST_DIFF   = 5'd21;

    function automatic uword_t mk_uw(input a_sel_t a, input b_sel_t b, input logic hi,
                                     input base_sel_t bs, input add_sel_t ad,
                                     input logic ty, input logic w0, input logic w1,
                                     input jump_t j, input step_t t);
        uword_t w;
        w.a_sel    = a;
        w.b_sel    = b;
        w.hi_half  = hi;
        w.base_sel = bs;
        w.add_sel  = ad;
        w.take_y   = ty;
        w.wr_s0    = w0;
        w.wr_s1    = w1;
        w.jump     = j;
        w.target   = t;
        return w;
    endfunction

    // Each word issues one half product; the accumulator adds the product issued by the
    // previous word. Low halves are unsigned, high halves signed and weighted up.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE, 1'b0, 1'b0, 1'b0, J_END, ST_IDLE);
        case (s)
            // Idle: wait for an item and branch on its command.
            5'd0:  w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                             1'b0, 1'b0, 1'b0, J_DISPATCH, ST_IDLE);
            // Filter: y = b0*x + s0, rounded.
            5'd1:  w = mk_uw(A_X, B_B0, 1'b0, BASE_S0, ADD_RND,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd2:  w = mk_uw(A_X, B_B0, 1'b1, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd3:  w = mk_uw(A_X, B_B1, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            // New s0 = b1*x + (s1 or zero) - a1*y.
            5'd4:  w = mk_uw(A_X, B_B1, 1'b1, BASE_S1Z, ADD_PLUS,
                             1'b1, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd5:  w = mk_uw(A_Y, B_A1, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd6:  w = mk_uw(A_Y, B_A1, 1'b1, BASE_ACC, ADD_MINUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd7:  w = mk_uw(A_X, B_B2, 1'b0, BASE_ACC, ADD_MINUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            // New s1 = b2*x - a2*y, second order only.
            5'd8:  w = mk_uw(A_X, B_B2, 1'b1, BASE_ZERO, ADD_PLUS,
                             1'b0, 1'b1, 1'b0, J_IF_FIRST, ST_EMIT);
            5'd9:  w = mk_uw(A_Y, B_A2, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd10: w = mk_uw(A_Y, B_A2, 1'b1, BASE_ACC, ADD_MINUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd11: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_MINUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd12: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                             1'b0, 1'b0, 1'b1, J_NEXT, ST_IDLE);
            5'd13: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                             1'b0, 1'b0, 1'b0, J_EMIT, ST_IDLE);
            // Steady preset: s0 = p*(1 - b0), then, second order only, s1 = s0 + p*(a1 - b1).
            5'd14: w = mk_uw(A_X, B_OMB0, 1'b0, BASE_ZERO, ADD_NONE,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd15: w = mk_uw(A_X, B_OMB0, 1'b1, BASE_ZERO, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd16: w = mk_uw(A_X, B_A1MB1, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd17: w = mk_uw(A_X, B_A1MB1, 1'b1, BASE_ZERO, ADD_PLUS,
                             1'b0, 1'b1, 1'b0, J_IF_FIRST, ST_IDLE);
            5'd18: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd19: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_S0,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd20: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                             1'b0, 1'b0, 1'b1, J_END, ST_IDLE);
            // Differentiator preset: s0 = p*b1.
            5'd21: w = mk_uw(A_X, B_B1, 1'b0, BASE_ZERO, ADD_NONE,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd22: w = mk_uw(A_X, B_B1, 1'b1, BASE_ZERO, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd23: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_PLUS,
                             1'b0, 1'b0, 1'b0, J_NEXT, ST_IDLE);
            5'd24: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                             1'b0, 1'b1, 1'b0, J_END, ST_IDLE);
            default: w = mk_uw(A_X, B_B0, 1'b0, BASE_ACC, ADD_NONE,
                               1'b0, 1'b0, 1'b0, J_END, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/bqc_seq.sv]
// Microprogram sequencer: step counter, microcode ROM lookup and jump logic.
// Depends on bqc_pkg.
`default_nettype none

module bqc_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        command,
    input  wire logic              second_order,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    output logic                   in_stall,
    output bqc_pkg::seq_ctl_t      ctl
);
    import bqc_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   out_free;

    assign uw       = ucode(step_reg);
    assign in_stall = (step_reg != ST_IDLE);
    assign out_free = !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        step_next   = step_t'(step_reg + 5'd1);
        ctl.uw      = uw;
        ctl.load    = 1'b0;
        ctl.emit    = 1'b0;
        case (uw.jump)
            J_NEXT:
            begin
                step_next = step_t'(step_reg + 5'd1);
            end
            J_DISPATCH:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (cmd_t'(command))
                        CMD_FILTER, CMD_CLAMP: step_next = ST_FILT;
                        CMD_STEADY:            step_next = ST_STEADY;
                        CMD_DIFF:              step_next = ST_DIFF;
                    endcase
                end
                else
                begin
                    step_next = step_reg;
                end
            end
            J_IF_FIRST:
            begin
                if (!second_order)
                begin
                    step_next = uw.target;
                end
            end
            J_END:
            begin
                step_next = ST_IDLE;
            end
            J_EMIT:
            begin
                // The result waits here until the output register can take it.
                if (out_free)
                begin
                    ctl.emit  = 1'b1;
                    step_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg;
                end
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/bqc_datapath.sv]
// Filter datapath: shared half-width multiplier, wide accumulator, state registers,
// output rounding, saturation and clamp. Driven by the microword from bqc_seq.
// Depends on bqc_pkg.
`default_nettype none

module bqc_datapath #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bqc_pkg::seq_ctl_t              ctl,
    input  wire logic [1:0]                     command,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b0,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b1,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b2,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_a1,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_a2,
    input  wire logic                           second_order,
    input  wire logic signed [SAMPLE_WIDTH-1:0] clamp_low,
    input  wire logic signed [SAMPLE_WIDTH-1:0] clamp_high,
    output logic signed [SAMPLE_WIDTH-1:0]      y_out
);
    import bqc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_WIDTH;
    // Operand width holds a coefficient, 1.0 minus a coefficient, or a difference.
    localparam int BW = ((CW > COEF_FRAC + 1) ? CW : COEF_FRAC + 1) + 1;
    localparam int LH = (BW + 1) / 2;
    localparam int HH = BW - LH;
    localparam int PW = SW + LH + 1;
    localparam int AW = ((SW + BW > STATE_WIDTH) ? SW + BW : STATE_WIDTH) + 2;

    localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] S_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [STATE_WIDTH-1:0] S_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] RND = AW'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [BW-1:0] B_ONE = BW'(COEF_ONE);

    logic signed [SW-1:0]          x_reg;
    cmd_t                          cmd_reg;
    logic signed [SW-1:0]          y_reg;
    logic signed [STATE_WIDTH-1:0] s0_reg;
    logic signed [STATE_WIDTH-1:0] s1_reg;
    logic signed [PW-1:0]          prod_reg;
    logic                          hi_d_reg;
    logic signed [AW-1:0]          acc_reg;
    logic signed [AW-1:0]          acc_next;

    logic signed [BW-1:0]          b0_x, b1_x, b2_x, a1_x, a2_x, omb0, a1mb1, b_full;
    logic signed [SW-1:0]          a_op;
    logic signed [LH:0]            b_op;
    logic signed [PW-1:0]          prod;
    logic signed [AW-1:0]          prod_ext;
    logic signed [AW-1:0]          term;
    logic signed [AW-1:0]          base_val;
    logic signed [AW-1:0]          addend;
    logic signed [AW-1:0]          acc_sh;
    logic                          y_fits;
    logic signed [SW-1:0]          y_sat;
    logic signed [SW-1:0]          y_final;
    logic                          s_fits;
    logic signed [STATE_WIDTH-1:0] s_sat;

    assign b0_x  = {{(BW-CW){coef_b0[CW-1]}}, coef_b0};
    assign b1_x  = {{(BW-CW){coef_b1[CW-1]}}, coef_b1};
    assign b2_x  = {{(BW-CW){coef_b2[CW-1]}}, coef_b2};
    assign a1_x  = {{(BW-CW){coef_a1[CW-1]}}, coef_a1};
    assign a2_x  = {{(BW-CW){coef_a2[CW-1]}}, coef_a2};
    assign omb0  = B_ONE - b0_x;
    assign a1mb1 = a1_x - b1_x;

    always_comb
    begin
        case (ctl.uw.b_sel)
            B_B0:    b_full = b0_x;
            B_B1:    b_full = b1_x;
            B_B2:    b_full = b2_x;
            B_A1:    b_full = a1_x;
            B_A2:    b_full = a2_x;
            B_OMB0:  b_full = omb0;
            B_A1MB1: b_full = a1mb1;
            default: b_full = b0_x;
        endcase
    end

    // Low half goes in as an unsigned value, the high half keeps the sign.
    assign a_op = (ctl.uw.a_sel == A_Y) ? y_reg : x_reg;
    assign b_op = ctl.uw.hi_half
                ? {{(LH+1-HH){b_full[BW-1]}}, b_full[BW-1:LH]}
                : {1'b0, b_full[LH-1:0]};
    assign prod = a_op * b_op;

    assign prod_ext = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
    assign term     = hi_d_reg ? (prod_ext <<< LH) : prod_ext;

    always_comb
    begin
        unique case (ctl.uw.base_sel)
            BASE_ACC:  base_val = acc_reg;
            BASE_ZERO: base_val = '0;
            BASE_S0:   base_val = {{(AW-STATE_WIDTH){s0_reg[STATE_WIDTH-1]}}, s0_reg};
            BASE_S1Z:  base_val = second_order
                                ? {{(AW-STATE_WIDTH){s1_reg[STATE_WIDTH-1]}}, s1_reg}
                                : '0;
        endcase
        case (ctl.uw.add_sel)
            ADD_NONE:  addend = '0;
            ADD_PLUS:  addend = term;
            ADD_MINUS: addend = -term;
            ADD_RND:   addend = RND;
            ADD_S0:    addend = {{(AW-STATE_WIDTH){s0_reg[STATE_WIDTH-1]}}, s0_reg};
            default:   addend = '0;
        endcase
        acc_next = base_val + addend;
    end

    // Output rounding already sits in the accumulator; drop the fraction and saturate.
    assign acc_sh = acc_reg >>> COEF_FRAC;
    assign y_fits = (acc_sh[AW-1:SW-1] == {(AW-SW+1){acc_sh[SW-1]}});
    assign y_sat  = y_fits ? acc_sh[SW-1:0] : (acc_sh[AW-1] ? Y_MIN : Y_MAX);

    always_comb
    begin
        y_final = y_sat;
        if (cmd_reg == CMD_CLAMP)
        begin
            priority if (y_sat < clamp_low)
            begin
                y_final = clamp_low;
            end
            else if (y_sat > clamp_high)
            begin
                y_final = clamp_high;
            end
        end
    end

    assign s_fits = (acc_reg[AW-1:STATE_WIDTH-1] == {(AW-STATE_WIDTH+1){acc_reg[STATE_WIDTH-1]}});
    assign s_sat  = s_fits ? acc_reg[STATE_WIDTH-1:0] : (acc_reg[AW-1] ? S_MIN : S_MAX);

    assign y_out = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            if (ctl.uw.wr_s0)
            begin
                s0_reg <= s_sat;
            end
            if (ctl.uw.wr_s1)
            begin
                s1_reg <= s_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        hi_d_reg <= ctl.uw.hi_half;
        acc_reg  <= acc_next;
        if (ctl.load)
        begin
            x_reg   <= sample;
            cmd_reg <= cmd_t'(command);
        end
        if (ctl.uw.take_y)
        begin
            y_reg <= y_final;
        end
    end

endmodule

`default_nettype wire

[hdl/biquad_tdf2_filter_with_clamp.sv]
// Biquad IIR filter, transposed direct form II, with output clamp and state presets.
// Filter item, first or second order: one result; the next item is taken only after
// the result has moved to the output register.
// Presets: 7 steps (steady, second order), 4 steps otherwise; no result.
// Step count is set by the one shared multiplier, two half products per coefficient.
// Reset (async, active low) clears both states and loads b0 = 1.0, full-range clamps.
`default_nettype none

module biquad_tdf2_filter_with_clamp #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       cfg_write,
    input  wire logic [bqc_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire logic [((COEF_WIDTH > SAMPLE_WIDTH) ? COEF_WIDTH : SAMPLE_WIDTH)-1:0] cfg_data,
    input  wire logic                                       in_valid,
    output logic                                            in_stall,
    input  wire logic [1:0]                                 command,
    input  wire logic signed [SAMPLE_WIDTH-1:0]             sample,
    output logic                                            out_valid,
    input  wire logic                                       out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]                  filtered
);
    import bqc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_WIDTH;

    logic signed [CW-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                 second_order_reg;
    logic signed [SW-1:0] clamp_low_reg, clamp_high_reg;
    logic                 out_valid_reg;
    logic signed [SW-1:0] filtered_reg;
    logic signed [SW-1:0] y_out;
    seq_ctl_t             ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg           <= CW'(COEF_ONE);
            b1_reg           <= '0;
            b2_reg           <= '0;
            a1_reg           <= '0;
            a2_reg           <= '0;
            second_order_reg <= 1'b0;
            clamp_low_reg    <= {1'b1, {(SW-1){1'b0}}};
            clamp_high_reg   <= {1'b0, {(SW-1){1'b1}}};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_B0:           b0_reg           <= cfg_data[CW-1:0];
                CFG_B1:           b1_reg           <= cfg_data[CW-1:0];
                CFG_B2:           b2_reg           <= cfg_data[CW-1:0];
                CFG_A1:           a1_reg           <= cfg_data[CW-1:0];
                CFG_A2:           a2_reg           <= cfg_data[CW-1:0];
                CFG_SECOND_ORDER: second_order_reg <= cfg_data[0];
                CFG_CLAMP_LOW:    clamp_low_reg    <= cfg_data[SW-1:0];
                CFG_CLAMP_HIGH:   clamp_high_reg   <= cfg_data[SW-1:0];
            endcase
        end
    end

    bqc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .command      (command),
        .second_order (second_order_reg),
        .out_valid    (out_valid_reg),
        .out_stall    (out_stall),
        .in_stall     (in_stall),
        .ctl          (ctl)
    );

    bqc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .command      (command),
        .sample       (sample),
        .coef_b0      (b0_reg),
        .coef_b1      (b1_reg),
        .coef_b2      (b2_reg),
        .coef_a1      (a1_reg),
        .coef_a2      (a2_reg),
        .second_order (second_order_reg),
        .clamp_low    (clamp_low_reg),
        .clamp_high   (clamp_high_reg),
        .y_out        (y_out)
    );

    // Output register: a finished item waits here while the sequencer takes the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            filtered_reg <= y_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

`default_nettype wire
